FILE: src/rtog_pkg.sv
// ----------------------------------------------------------------------------
// region table overlap guard package
// request/response payload types, op codes and sequencer states
// ----------------------------------------------------------------------------
package rtog_pkg;

   localparam int unsigned ADDR_W = 64;

   typedef enum logic [2:0] {
      OP_ADD_MASTER   = 3'd0,
      OP_ADD_SLAVE    = 3'd1,
      OP_EN_MASTER    = 3'd2,
      OP_DIS_MASTER   = 3'd3,
      OP_EN_SLAVE     = 3'd4,
      OP_DIS_SLAVE    = 3'd5,
      OP_QUERY        = 3'd6,
      OP_CLEAR        = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [ADDR_W-1:0] range_start;
      logic [ADDR_W-1:0] range_size;
      logic              enable_at_once;
      logic [5:0]        slot_index;
      logic              skip_masters;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] result_index;
      logic       conflict_kind;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_READ,
      ST_CMP,
      ST_POP,
      ST_DONE
   } state_type;

endpackage

FILE: src/region_table_overlap_guard.sv
// ----------------------------------------------------------------------------
// region table overlap guard
// two region tables with enabled lists and a serial overlap check
// ----------------------------------------------------------------------------
//  channel | ports                       | direction
//  req     | req_valid req_stall req_data | in
//  rsp     | rsp_valid rsp_stall rsp_data | out
//
// add, enable and clear go from fetch straight to done; disabling an
// enabled slot passes through pop. a query walks each enabled entry
// through fetch, read and compare (single compare unit, registered read).
// reset is synchronous and empties both tables at once via used/enabled bits.
// req_stall is high from acceptance until the response is taken.
module region_table_overlap_guard
   import rtog_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

   // memories, index bit is table: 0 master, 1 slave
   logic [ADDR_W-1:0] starts_mem [2**(IW+1)];
   logic [ADDR_W-1:0] sizes_mem  [2**(IW+1)];
   logic [IW-1:0]     order_mem  [2**(IW+1)];
   logic [IW-1:0]     pos_mem    [2**(IW+1)];

   logic [TABLE_SLOTS-1:0] used_ff [2];
   logic [TABLE_SLOTS-1:0] used_in [2];
   logic [TABLE_SLOTS-1:0] en_ff   [2];
   logic [TABLE_SLOTS-1:0] en_in   [2];
   logic [CW-1:0]          cnt_ff  [2];
   logic [CW-1:0]          cnt_in  [2];

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      tbl_ff, tbl_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [IW-1:0] idx_ff, idx_in;

   logic [ADDR_W-1:0] rd_start, rd_size;
   logic [IW-1:0]     rd_order, rd_pos;

   // write ports
   logic              wr_reg;
   logic [IW:0]       wr_reg_addr;
   logic              wr_ord;
   logic [IW:0]       wr_ord_addr;
   logic [IW-1:0]     wr_ord_data;
   logic              wr_pos;
   logic [IW:0]       wr_pos_addr;
   logic [IW-1:0]     wr_pos_data;
   logic [IW:0]       rd_ord_addr, rd_reg_addr, rd_pos_addr;

   logic              free_found;
   logic [IW-1:0]     free_slot;
   logic              slot_ok;
   logic [IW-1:0]     slot_i;
   logic              hit;
   logic [ADDR_W:0]   q_end, r_end;

   // ---- lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[req_ff.mode[0]][i]) begin
            free_found = 1'b1;
            free_slot  = IW'(i);
         end
      end
   end

   assign slot_ok = 32'(req_ff.slot_index) < TABLE_SLOTS;
   assign slot_i  = IW'(req_ff.slot_index);

   // ---- overlap compare unit, 65-bit ends catch wrap
   assign q_end = {1'b0, req_ff.range_start} + {1'b0, req_ff.range_size};
   assign r_end = {1'b0, rd_start} + {1'b0, rd_size};
   always_comb begin
      if (req_ff.range_size == '0 || rd_size == '0) hit = 1'b0;
      else if (q_end[ADDR_W] || r_end[ADDR_W]) hit = 1'b1;
      else hit = !(q_end[ADDR_W-1:0] <= rd_start ||
                   r_end[ADDR_W-1:0] <= req_ff.range_start);
   end

   // ---- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_FETCH;
         ST_FETCH: begin
            priority if (req_ff.mode == OP_QUERY) begin
               if (pos_in < cnt_ff[tbl_in]) state_in = ST_READ;
               else if (!tbl_in) state_in = ST_FETCH;
               else state_in = ST_DONE;
            end else if ((req_ff.mode == OP_DIS_MASTER || req_ff.mode == OP_DIS_SLAVE)
                         && slot_ok && en_ff[tbl_ff][slot_i]) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ:  state_in = ST_CMP;
         ST_CMP: begin
            if (hit) state_in = ST_DONE;
            else state_in = ST_FETCH;
         end
         ST_POP:   state_in = ST_DONE;
         ST_DONE:  if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---- datapath and table updates
   always_comb begin
      req_in = req_ff;
      rsp_in = rsp_ff;
      tbl_in = tbl_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      used_in = used_ff;
      en_in = en_ff;
      cnt_in = cnt_ff;
      wr_reg = 1'b0;
      wr_reg_addr = {req_ff.mode[0], free_slot};
      wr_ord = 1'b0;
      wr_ord_addr = '0;
      wr_ord_data = '0;
      wr_pos = 1'b0;
      wr_pos_addr = '0;
      wr_pos_data = '0;
      rd_ord_addr = {tbl_ff, pos_ff[IW-1:0]};
      rd_pos_addr = {tbl_ff, slot_i};
      rd_reg_addr = {tbl_ff, rd_order};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               rsp_in = '0;
               pos_in = '0;
               unique case (op_type'(req_data.mode))
                  OP_EN_SLAVE, OP_DIS_SLAVE: tbl_in = 1'b1;
                  OP_QUERY:  tbl_in = req_data.skip_masters;
                  default:   tbl_in = 1'b0;
               endcase
            end
         end
         ST_FETCH: begin
            unique case (op_type'(req_ff.mode))
               OP_ADD_MASTER, OP_ADD_SLAVE: begin
                  if (free_found) begin
                     wr_reg = 1'b1;
                     used_in[req_ff.mode[0]][free_slot] = 1'b1;
                     rsp_in.ok = 1'b1;
                     rsp_in.result_index = 6'(free_slot);
                     if (req_ff.enable_at_once) begin
                        en_in[req_ff.mode[0]][free_slot] = 1'b1;
                        cnt_in[req_ff.mode[0]] = cnt_ff[req_ff.mode[0]] + 1'b1;
                        wr_ord = 1'b1;
                        wr_ord_addr = {req_ff.mode[0], cnt_ff[req_ff.mode[0]][IW-1:0]};
                        wr_ord_data = free_slot;
                        wr_pos = 1'b1;
                        wr_pos_addr = {req_ff.mode[0], free_slot};
                        wr_pos_data = cnt_ff[req_ff.mode[0]][IW-1:0];
                     end
                  end
               end
               OP_EN_MASTER, OP_EN_SLAVE: begin
                  if (slot_ok && used_ff[tbl_ff][slot_i]) begin
                     rsp_in.ok = 1'b1;
                     if (!en_ff[tbl_ff][slot_i]) begin
                        en_in[tbl_ff][slot_i] = 1'b1;
                        cnt_in[tbl_ff] = cnt_ff[tbl_ff] + 1'b1;
                        wr_ord = 1'b1;
                        wr_ord_addr = {tbl_ff, cnt_ff[tbl_ff][IW-1:0]};
                        wr_ord_data = slot_i;
                        wr_pos = 1'b1;
                        wr_pos_addr = {tbl_ff, slot_i};
                        wr_pos_data = cnt_ff[tbl_ff][IW-1:0];
                     end
                  end
               end
               OP_DIS_MASTER, OP_DIS_SLAVE: begin
                  rsp_in.ok = slot_ok;
                  // fetch the last list entry for the swap
                  rd_ord_addr = {tbl_ff, IW'(cnt_ff[tbl_ff] - 1'b1)};
               end
               OP_QUERY: begin
                  // master list exhausted, move on to slaves
                  if (pos_ff >= cnt_ff[tbl_ff] && !tbl_ff) begin
                     tbl_in = 1'b1;
                     pos_in = '0;
                  end
                  rd_ord_addr = {tbl_in, pos_in[IW-1:0]};
               end
               default: begin
                  for (int t = 0; t < 2; t++) begin
                     used_in[t] = '0;
                     en_in[t] = '0;
                     cnt_in[t] = '0;
                  end
                  rsp_in.ok = 1'b1;
               end
            endcase
         end
         ST_READ: begin
            idx_in = rd_order;
         end
         ST_CMP: begin
            pos_in = pos_ff + 1'b1;
            if (hit) begin
               rsp_in.ok = 1'b1;
               rsp_in.result_index = 6'(idx_ff);
               rsp_in.conflict_kind = tbl_ff;
            end
         end
         ST_POP: begin
            // rd_order holds the moved slot, rd_pos the freed position
            if (32'(rd_pos) != 32'(cnt_ff[tbl_ff]) - 1) begin
               wr_ord = 1'b1;
               wr_ord_addr = {tbl_ff, rd_pos};
               wr_ord_data = rd_order;
               wr_pos = 1'b1;
               wr_pos_addr = {tbl_ff, rd_order};
               wr_pos_data = rd_pos;
            end
            cnt_in[tbl_ff] = cnt_ff[tbl_ff] - 1'b1;
            en_in[tbl_ff][slot_i] = 1'b0;
         end
         default: ;
      endcase
   end

   // ---- memories
   always_ff @(posedge clock) begin
      if (wr_reg) begin
         starts_mem[wr_reg_addr] <= req_ff.range_start;
         sizes_mem[wr_reg_addr]  <= req_ff.range_size;
      end
      if (wr_ord) order_mem[wr_ord_addr] <= wr_ord_data;
      if (wr_pos) pos_mem[wr_pos_addr] <= wr_pos_data;
      rd_order <= order_mem[rd_ord_addr];
      rd_pos   <= pos_mem[rd_pos_addr];
      rd_start <= starts_mem[rd_reg_addr];
      rd_size  <= sizes_mem[rd_reg_addr];
   end

   // ---- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int t = 0; t < 2; t++) begin
            used_ff[t] <= '0;
            en_ff[t]   <= '0;
            cnt_ff[t]  <= '0;
         end
         tbl_ff <= 1'b0;
         pos_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         en_ff    <= en_in;
         cnt_ff   <= cnt_in;
         tbl_ff   <= tbl_in;
         pos_ff   <= pos_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
   end

   // ---- outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      rsp_data  = rsp_ff;
   end

`ifndef SYNTHESIS
   a_cnt_match_m: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff[0]) == $countones(en_ff[0]))
      else $error("master list count differs from enabled bits");
   a_cnt_match_s: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff[1]) == $countones(en_ff[1]))
      else $error("slave list count differs from enabled bits");
   a_en_used: assert property (@(posedge clock) disable iff (reset)
      ((en_ff[0] & ~used_ff[0]) == '0) && ((en_ff[1] & ~used_ff[1]) == '0))
      else $error("enabled slot not in use");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");
`endif

endmodule
